[hw/rtl/hptp_pkg.sv]
`default_nettype none
package hptp_pkg;

   // one parsed character's worth of output: a run of value bytes then an optional tail byte
   typedef struct packed {
      logic [63:0] value;
      logic [3:0]  count;
      logic        swap;
      logic        tail_valid;
      logic [7:0]  tail_byte;
      logic        tail_known;
      logic        tail_unsup;
      logic        clear;
   } entry_type;

endpackage
`default_nettype wire

[hw/rtl/hptp_front.sv]
`default_nettype none
module hptp_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_we,
   input  wire                   csr_wdata,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire  [7:0]            req_tdata,   // character
   input  wire                   req_tlast,   // end_of_text
   input  wire                   q_full,
   output logic                  q_push,
   output hptp_pkg::entry_type   q_entry
);
   import hptp_pkg::*;

   typedef enum logic [2:0] {
      MODE_HEX, MODE_DSTR, MODE_SSTR, MODE_NHASH, MODE_NBODY, MODE_FLOAT, MODE_FILE
   } mode_type;

   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_PCT = 8'h25;
   localparam logic [7:0] CH_LT = 8'h3C;
   localparam logic [7:0] CH_GT = 8'h3E;
   localparam logic [7:0] CH_DQ = 8'h22;
   localparam logic [7:0] CH_SQ = 8'h27;
   localparam logic [7:0] CH_BSL = 8'h5C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT = 8'h2E;

   mode_type    mode_ff, mode_in;
   logic        esc_ff, esc_in;
   logic        nibp_ff, nibp_in;
   logic [3:0]  hn_ff, hn_in;
   logic        swap_ff, swap_in;
   logic [2:0]  hc_ff, hc_in;
   logic [63:0] val_ff, val_in;
   logic        neg_ff, neg_in;
   logic        sat_ff, sat_in;
   logic        mask_ff;

   function automatic logic [7:0] unesc(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c == 8'h6E) r = 8'h0A;
      else if (c == 8'h72) r = 8'h0D;
      else if (c == 8'h74) r = 8'h09;
      return r;
   endfunction

   logic [7:0]  ch;
   logic        fire, digit, flush, do_hex, acc;
   logic [4:0]  nib;
   logic [67:0] prod;
   entry_type   e;

   assign req_tready = !q_full;
   assign fire = req_tvalid && req_tready;
   assign ch = req_tdata;
   assign digit = (ch >= 8'h30) && (ch <= 8'h39);
   assign prod = ({4'b0, val_ff} << 3) + ({4'b0, val_ff} << 1) + {64'b0, ch[3:0]};

   always_comb begin
      mode_in = mode_ff; esc_in = esc_ff; nibp_in = nibp_ff; hn_in = hn_ff;
      swap_in = swap_ff; hc_in = hc_ff; val_in = val_ff; neg_in = neg_ff; sat_in = sat_ff;
      e = '0;
      e.swap = swap_ff;
      flush = 1'b0; do_hex = 1'b0; acc = 1'b0;
      nib = 5'd16;
      if (req_tlast) begin
         flush = (mode_ff == MODE_NHASH) || (mode_ff == MODE_NBODY);
      end else begin
         case (mode_ff)
            MODE_DSTR: begin
               if (esc_ff) begin
                  esc_in = 1'b0; e.count = 4'd1; e.value = {56'b0, unesc(ch)};
               end else if (ch == CH_DQ) mode_in = MODE_HEX;
               else if (ch == CH_BSL) esc_in = 1'b1;
               else begin
                  e.count = 4'd1; e.value = {56'b0, ch};
               end
            end
            MODE_SSTR: begin
               if (esc_ff) begin
                  esc_in = 1'b0; e.count = 4'd2; e.value = {56'b0, unesc(ch)};
               end else if (ch == CH_SQ) mode_in = MODE_HEX;
               else if (ch == CH_BSL) esc_in = 1'b1;
               else begin
                  e.count = 4'd2; e.value = {56'b0, ch};
               end
            end
            MODE_NHASH: begin
               if (ch == CH_HASH && hc_ff < 3'd4) hc_in = hc_ff + 3'd1;
               else if (ch == CH_MINUS) begin
                  neg_in = 1'b1; mode_in = MODE_NBODY;
               end else if (digit) begin
                  acc = 1'b1; mode_in = MODE_NBODY;
               end else begin
                  flush = 1'b1; do_hex = 1'b1;
               end
            end
            MODE_NBODY: begin
               if (digit) acc = 1'b1;
               else begin
                  flush = 1'b1; do_hex = 1'b1;
               end
            end
            MODE_FLOAT: begin
               if (hc_ff == 3'd0 && ch == CH_PCT) hc_in = 3'd1;
               else if (hc_ff <= 3'd1 && ch == CH_MINUS) hc_in = 3'd2;
               else if (digit || ch == CH_DOT) hc_in = 3'd2;
               else begin
                  mode_in = MODE_HEX; hc_in = 3'd0; do_hex = 1'b1;
               end
            end
            MODE_FILE: begin
               if (ch == CH_GT) mode_in = MODE_HEX;
            end
            default: begin
               mode_in = MODE_HEX; do_hex = 1'b1;
            end
         endcase
      end
      if (acc && !sat_ff) begin
         if (prod[67:64] != 4'b0) sat_in = 1'b1;
         else val_in = prod[63:0];
      end
      if (flush) begin
         if (sat_ff) e.value = '1;
         else if (neg_ff) e.value = 64'd0 - val_ff;
         else e.value = val_ff;
         e.count = 4'd1 << (2'(hc_ff - 3'd1));
         mode_in = MODE_HEX; hc_in = 3'd0; val_in = '0; neg_in = 1'b0; sat_in = 1'b0;
      end
      if (do_hex) begin
         if (ch >= 8'h30 && ch <= 8'h39) nib = {1'b0, ch[3:0]};
         else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
            nib = {1'b0, ch[3:0] + 4'd9};
         if (ch == CH_QUEST && mask_ff) begin
            e.tail_valid = 1'b1;
         end else if (ch == CH_DOLLAR) swap_in = !swap_ff;
         else if (ch == CH_HASH) begin
            mode_in = MODE_NHASH; hc_in = 3'd1; val_in = '0; neg_in = 1'b0; sat_in = 1'b0;
         end else if (ch == CH_PCT) begin
            mode_in = MODE_FLOAT; hc_in = 3'd0; e.tail_valid = 1'b1; e.tail_unsup = 1'b1;
         end else if (ch == CH_LT) begin
            mode_in = MODE_FILE; e.tail_valid = 1'b1; e.tail_unsup = 1'b1;
         end else if (ch == CH_DQ) begin
            mode_in = MODE_DSTR; esc_in = 1'b0;
         end else if (ch == CH_SQ) begin
            mode_in = MODE_SSTR; esc_in = 1'b0;
         end else if (!nib[4]) begin
            if (!nibp_ff) begin
               hn_in = nib[3:0]; nibp_in = 1'b1;
            end else begin
               e.tail_valid = 1'b1; e.tail_known = 1'b1; e.tail_byte = {hn_ff, nib[3:0]};
               nibp_in = 1'b0; hn_in = 4'd0;
            end
         end
      end
      if (req_tlast) begin
         e.clear = 1'b1;
         mode_in = MODE_HEX; esc_in = 1'b0; nibp_in = 1'b0; hn_in = 4'd0; swap_in = 1'b0;
         hc_in = 3'd0; val_in = '0; neg_in = 1'b0; sat_in = 1'b0;
      end
   end

   assign q_entry = e;
   assign q_push = fire && (e.count != 4'd0 || e.tail_valid || e.clear);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HEX; esc_ff <= 1'b0; nibp_ff <= 1'b0; hn_ff <= 4'd0;
         swap_ff <= 1'b0; hc_ff <= 3'd0; val_ff <= '0; neg_ff <= 1'b0; sat_ff <= 1'b0;
         mask_ff <= 1'b1;
      end else begin
         if (csr_we) mask_ff <= csr_wdata;
         if (fire) begin
            mode_ff <= mode_in; esc_ff <= esc_in; nibp_ff <= nibp_in; hn_ff <= hn_in;
            swap_ff <= swap_in; hc_ff <= hc_in; val_ff <= val_in; neg_ff <= neg_in;
            sat_ff <= sat_in;
         end
      end
   end
endmodule
`default_nettype wire

[hw/rtl/hptp_queue.sv]
`default_nettype none
module hptp_queue #(
   parameter int DEPTH = 4
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  hptp_pkg::entry_type   push_entry,
   output logic                  full,
   input  wire                   pop,
   output logic                  empty,
   output hptp_pkg::entry_type   head
);
   import hptp_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [CW-1:0]    cnt_ff;
   logic             do_push, do_pop;

   assign full = cnt_ff == CW'(DEPTH);
   assign empty = cnt_ff == '0;
   assign head = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (do_pop) rd_ff <= (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         if (do_push && !do_pop) cnt_ff <= cnt_ff + 1'b1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 1'b1;
      end
   end
endmodule
`default_nettype wire

[hw/rtl/hptp_back.sv]
`default_nettype none
module hptp_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   q_empty,
   input  hptp_pkg::entry_type   q_head,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [39:0]           rsp_tdata,   // data_byte, byte_offset
   output logic [1:0]            rsp_tuser,   // known, unsupported
   output logic                  rsp_tlast    // last_of_run
);
   import hptp_pkg::*;

   logic        ov_ff;
   logic [7:0]  ob_ff;
   logic [31:0] oo_ff;
   logic        ok_ff, ou_ff, ol_ff;
   logic [3:0]  idx_ff;
   logic [31:0] off_ff;

   logic        can, emit, is_num, last;
   logic [4:0]  total;
   logic [2:0]  sh;
   logic [7:0]  byte_sel;
   logic        unsup_sel;

   assign can = !ov_ff || rsp_tready;
   assign total = {1'b0, q_head.count} + {4'b0, q_head.tail_valid};
   assign is_num = idx_ff < q_head.count;
   assign sh = q_head.swap ? 3'(q_head.count - 4'd1 - idx_ff) : idx_ff[2:0];
   assign byte_sel = is_num ? q_head.value[{sh, 3'b0} +: 8] :
                     (q_head.tail_known ? q_head.tail_byte : 8'd0);
   assign unsup_sel = !is_num && q_head.tail_unsup;
   assign emit = can && !q_empty && total != 5'd0;
   assign last = {1'b0, idx_ff} == total - 5'd1;
   assign q_pop = can && !q_empty && (total == 5'd0 || last);

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0; idx_ff <= 4'd0; off_ff <= '0;
      end else begin
         if (can) ov_ff <= emit;
         if (emit) begin
            if (!unsup_sel && off_ff != 32'hFFFF_FFFF) off_ff <= off_ff + 32'd1;
            idx_ff <= last ? 4'd0 : idx_ff + 4'd1;
         end
         if (q_pop && q_head.clear) off_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         ob_ff <= byte_sel; oo_ff <= off_ff; ok_ff <= is_num || q_head.tail_known;
         ou_ff <= unsup_sel; ol_ff <= last;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = {oo_ff, ob_ff};
   assign rsp_tuser = {ou_ff, ok_ff};
   assign rsp_tlast = ol_ff;
endmodule
`default_nettype wire

[hw/rtl/hex_pattern_text_parser_core.sv]
// byte-pattern text parser
// req channel: one text character per word in req_tdata[7:0]; req_tlast marks end of
// text (the character is then ignored, a pending number is flushed, parser state clears).
// rsp channel: pattern bytes, rsp_tdata = {byte_offset, data_byte}, rsp_tuser =
// {unsupported, known}, rsp_tlast on the final byte caused by one request word.
// csr_we/csr_wdata write mask_enabled (reset 1); the user must write it only while the
// block is idle; the block does not enforce this. the front parser takes one character
// per cycle while the queue is not full and pushes its bytes as one queue entry; the
// back end emits one byte per cycle from the queue head while rsp_tready allows, so a
// character holds the output for all its bytes (up to 9 for a flushed 8-byte number).
// sustained rate: one character per cycle while each yields at most one byte and
// rsp_tready is high. when rsp_tready is low the output register holds, the queue
// fills and req_tready drops once QUEUE_DEPTH entries wait.
// reset empties the queue and output register and returns the parser to hex mode.
`default_nettype none
module hex_pattern_text_parser_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          csr_we,
   input  wire          csr_wdata,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,   // character
   input  wire          req_tlast,   // end_of_text
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [39:0]  rsp_tdata,   // data_byte, byte_offset
   output logic [1:0]   rsp_tuser,   // known, unsupported
   output logic         rsp_tlast    // last_of_run
);
   import hptp_pkg::*;

   entry_type push_entry, head;
   logic      push, full, pop, empty;

   hptp_front u_front (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .q_full(full), .q_push(push), .q_entry(push_entry)
   );

   hptp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_entry(push_entry), .full(full),
      .pop(pop), .empty(empty), .head(head)
   );

   hptp_back u_back (
      .clock(clock), .reset(reset), .q_empty(empty), .q_head(head), .q_pop(pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );
endmodule
`default_nettype wire
